// ===== rtl/core/i2cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

	// Active command. The values match the operation codes of a request.
	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4,
		CMD_WAIT  = 3'd5
	} cmd_t;

	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [7:0] POLL_MAX      = 8'hFF;
	localparam logic [7:0] LIMIT_RESET   = 8'd200;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] write_data;
		logic       send_ack;
		logic       sda_sample;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_failed;
	} res_t;

endpackage

// ===== rtl/core/i2c_master_bit_engine_unit.sv =====
// Request and result are registered; one tick request per cycle unless stalled.
// The sequencer state updates in one pass.
// in_stall rises only while the result register is held by out_stall.
// Reset (arst_n low, asynchronous): idle, both lines released, counters and
// read byte cleared, ack_wait_limit back to 200, no valid request or result.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// I2C master pin engine: one bus tick per request, one result per tick.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [7:0] write_data,
	input  logic       send_ack,
	input  logic       sda_sample,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       sda_level,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       ack_failed,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	i2cmbe_pkg::item_t item_in, item_s1;
	i2cmbe_pkg::res_t  res, res_q;
	logic              valid_s1;
	logic              advance;
	logic [7:0]        limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= i2cmbe_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_comb begin
		item_in.operation  = operation;
		item_in.write_data = write_data;
		item_in.send_ack   = send_ack;
		item_in.sda_sample = sda_sample;
	end

	i2cmbe_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item_in  (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	i2cmbe_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (valid_s1 && advance),
		.item_s1        (item_s1),
		.ack_wait_limit (limit_q),
		.res            (res)
	);

	i2cmbe_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.out_stall (out_stall),
		.advance   (advance),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign scl_level  = res_q.scl_level;
	assign sda_level  = res_q.sda_level;
	assign busy_res   = res_q.busy_res;
	assign done_res   = res_q.done_res;
	assign read_data  = res_q.read_data;
	assign ack_failed = res_q.ack_failed;

endmodule

// ===== rtl/core/i2cmbe_in_stage.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_in_stage
// Input register: holds one request until the step logic consumes it.
// ----------------------------------------------------------------------------
module i2cmbe_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  i2cmbe_pkg::item_t   item_in,
	input  logic                advance,
	output logic                valid_s1,
	output i2cmbe_pkg::item_t   item_s1
);

	logic take;

	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ===== rtl/core/i2cmbe_core.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_core
// Bus sequencer: command state, bit and poll counters, and the pin levels,
// advanced by one tick per consumed request.
// ----------------------------------------------------------------------------
module i2cmbe_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  i2cmbe_pkg::item_t   item_s1,
	input  logic [7:0]          ack_wait_limit,
	output i2cmbe_pkg::res_t    res
);

	i2cmbe_pkg::cmd_t cmd_q, cmd_d, cmd_e;
	logic [1:0] phase_q, phase_d, phase_e;
	logic [3:0] bits_q, bits_d, bits_e;
	logic [7:0] shift_q, shift_d, shift_e;
	logic [7:0] poll_q, poll_d, poll_e;
	logic       ackc_q, ackc_d, ackc_e;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic [7:0] hold_q, hold_d;
	logic       fail_q, fail_d, fail_e;
	logic       launch;
	logic       done_w;
	logic       timeout_w;
	logic [7:0] poll_inc;

	// A new command is taken only when idle; codes zero, six and seven are ticks.
	assign launch = (cmd_q == i2cmbe_pkg::CMD_IDLE) &&
		(item_s1.operation inside {[i2cmbe_pkg::CMD_START:i2cmbe_pkg::CMD_WAIT]});

	always_comb begin
		cmd_e   = cmd_q;
		phase_e = phase_q;
		bits_e  = bits_q;
		shift_e = shift_q;
		poll_e  = poll_q;
		ackc_e  = ackc_q;
		fail_e  = fail_q;
		if (launch) begin
			cmd_e   = i2cmbe_pkg::cmd_t'(item_s1.operation);
			phase_e = i2cmbe_pkg::PH_0;
			bits_e  = '0;
			poll_e  = '0;
			fail_e  = 1'b0;
			if (cmd_e == i2cmbe_pkg::CMD_WRITE) begin
				shift_e = item_s1.write_data;
			end else if (cmd_e == i2cmbe_pkg::CMD_READ) begin
				shift_e = '0;
				ackc_e  = item_s1.send_ack;
			end
		end
	end

	assign poll_inc = (poll_e < i2cmbe_pkg::POLL_MAX) ? poll_e + 8'd1 : poll_e;

	// Pin levels, counters and flags for this tick.
	always_comb begin
		phase_d   = phase_e;
		bits_d    = bits_e;
		shift_d   = shift_e;
		poll_d    = poll_e;
		ackc_d    = ackc_e;
		fail_d    = fail_e;
		scl_d     = scl_q;
		sda_d     = sda_q;
		hold_d    = hold_q;
		done_w    = 1'b0;
		timeout_w = 1'b0;
		case (cmd_e)
			i2cmbe_pkg::CMD_START: begin
				if (phase_e == i2cmbe_pkg::PH_0) begin
					scl_d = 1'b1; sda_d = 1'b1; phase_d = i2cmbe_pkg::PH_1;
				end else if (phase_e == i2cmbe_pkg::PH_1) begin
					sda_d = 1'b0; phase_d = i2cmbe_pkg::PH_2;
				end else begin
					scl_d = 1'b0; done_w = 1'b1;
				end
			end
			i2cmbe_pkg::CMD_STOP: begin
				if (phase_e == i2cmbe_pkg::PH_0) begin
					scl_d = 1'b0; sda_d = 1'b0; phase_d = i2cmbe_pkg::PH_1;
				end else if (phase_e == i2cmbe_pkg::PH_1) begin
					scl_d = 1'b1; phase_d = i2cmbe_pkg::PH_2;
				end else begin
					sda_d = 1'b1; done_w = 1'b1;
				end
			end
			i2cmbe_pkg::CMD_WRITE: begin
				if (phase_e == i2cmbe_pkg::PH_0) begin
					scl_d = 1'b0; sda_d = shift_e[7]; phase_d = i2cmbe_pkg::PH_1;
				end else if (phase_e == i2cmbe_pkg::PH_1) begin
					scl_d = 1'b1; phase_d = i2cmbe_pkg::PH_2;
				end else begin
					scl_d   = 1'b0;
					shift_d = {shift_e[6:0], 1'b0};
					bits_d  = bits_e + 4'd1;
					phase_d = i2cmbe_pkg::PH_0;
					done_w  = (bits_d >= i2cmbe_pkg::BITS_PER_BYTE);
				end
			end
			i2cmbe_pkg::CMD_READ: begin
				if (bits_e < i2cmbe_pkg::BITS_PER_BYTE) begin
					if (phase_e == i2cmbe_pkg::PH_0) begin
						scl_d = 1'b0; sda_d = 1'b1; phase_d = i2cmbe_pkg::PH_1;
					end else begin
						// sample on the rising SCL tick
						scl_d   = 1'b1;
						shift_d = {shift_e[6:0], item_s1.sda_sample};
						bits_d  = bits_e + 4'd1;
						phase_d = i2cmbe_pkg::PH_0;
						if (bits_d == i2cmbe_pkg::BITS_PER_BYTE) begin
							hold_d = shift_d;
						end
					end
				end else if (phase_e == i2cmbe_pkg::PH_0) begin
					scl_d = 1'b0; sda_d = !ackc_e; phase_d = i2cmbe_pkg::PH_1;
				end else if (phase_e == i2cmbe_pkg::PH_1) begin
					scl_d = 1'b1; phase_d = i2cmbe_pkg::PH_2;
				end else begin
					scl_d = 1'b0; done_w = 1'b1;
				end
			end
			i2cmbe_pkg::CMD_WAIT: begin
				if (phase_e == i2cmbe_pkg::PH_0) begin
					sda_d = 1'b1; phase_d = i2cmbe_pkg::PH_1;
				end else if (phase_e == i2cmbe_pkg::PH_1) begin
					scl_d = 1'b1; phase_d = i2cmbe_pkg::PH_2;
				end else if (!item_s1.sda_sample) begin
					scl_d = 1'b0; done_w = 1'b1;
				end else begin
					poll_d = poll_inc;
					if (poll_inc >= ack_wait_limit) begin
						// give up: drop both lines and finish with the stop tail
						timeout_w = 1'b1;
						fail_d    = 1'b1;
						scl_d     = 1'b0;
						sda_d     = 1'b0;
						phase_d   = i2cmbe_pkg::PH_1;
					end
				end
			end
			default: begin
			end
		endcase
		if (done_w) begin
			phase_d = i2cmbe_pkg::PH_0;
		end
	end

	// Next command.
	always_comb begin
		cmd_d = cmd_e;
		if (done_w) begin
			cmd_d = i2cmbe_pkg::CMD_IDLE;
		end else if (timeout_w) begin
			cmd_d = i2cmbe_pkg::CMD_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= i2cmbe_pkg::CMD_IDLE;
			phase_q <= i2cmbe_pkg::PH_0;
			bits_q  <= '0;
			shift_q <= '0;
			poll_q  <= '0;
			ackc_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			hold_q  <= '0;
			fail_q  <= 1'b0;
		end else if (step_en) begin
			cmd_q   <= cmd_d;
			phase_q <= phase_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			poll_q  <= poll_d;
			ackc_q  <= ackc_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			hold_q  <= hold_d;
			fail_q  <= fail_d;
		end
	end

	always_comb begin
		res.scl_level  = scl_d;
		res.sda_level  = sda_d;
		res.busy_res   = (cmd_d != i2cmbe_pkg::CMD_IDLE);
		res.done_res   = done_w;
		res.read_data  = hold_d;
		res.ack_failed = fail_d;
	end

endmodule

// ===== rtl/core/i2cmbe_out_stage.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_out_stage
// Result register: holds one tick result until downstream takes it.
// ----------------------------------------------------------------------------
module i2cmbe_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  i2cmbe_pkg::res_t    res,
	input  logic                out_stall,
	output logic                advance,
	output logic                out_valid,
	output i2cmbe_pkg::res_t    res_q
);

	assign advance = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res;
		end
	end

endmodule

// ===== rtl/core/i2cmbe_checker.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_checker
// Port-level checks for the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmbe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl_level,
	input logic       sda_level,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_data,
	input logic       ack_failed
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(scl_level) && $stable(sda_level) &&
			$stable(busy_res) && $stable(done_res) && $stable(read_data) &&
			$stable(ack_failed))
		else $error("result changed while stalled");

	// a finished command leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done with engine still busy");

	// every sequence ends with SCL low, or with the bus released after a stop
	a_done_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !scl_level || sda_level)
		else $error("command finished with SCL high and SDA low");

endmodule

bind i2c_master_bit_engine_unit i2cmbe_checker u_i2cmbe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.scl_level  (scl_level),
	.sda_level  (sda_level),
	.busy_res   (busy_res),
	.done_res   (done_res),
	.read_data  (read_data),
	.ack_failed (ack_failed)
);
